// File: rtl/lfukv_pkg.sv
// ----------------------------------------------------------------------------
// lfukv_pkg
// Shared constants for the LFU key/value cache: field widths, operation codes
// and the reset value of the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

package lfukv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

endpackage

`default_nettype wire

// File: rtl/lfukv_cell.sv
// ----------------------------------------------------------------------------
// lfukv_cell
// One cache slot of the chain. It holds a key, a value, a use count and a
// recency rank, folds its own slot into the scan record handed down the chain
// every cycle, and applies the update command broadcast at the end of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lfukv_cell
  import lfukv_pkg::*;
#(
  parameter int  CELL_IDX = 0,
  parameter int  IDX_W    = 4,
  parameter int  CNT_W    = 16,
  parameter type link_t   = logic,
  parameter type cmd_t    = logic
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [KEY_W-1:0] key_i,
  input  link_t                 link_i,
  output link_t                 link_o,
  input  cmd_t                  cmd_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] rank_r;

  link_t link_r;
  link_t link_nxt;

  logic match;
  logic take_vic;
  logic is_vic;
  logic is_ins;
  logic rank_dec;

  assign match = valid_r && (key_r == key_i);

  // Victim order: smaller count wins; on equal counts the older entry wins.
  // Strict compares keep the lowest slot when both are equal.
  assign take_vic = valid_r && (!link_i.vic_found || (count_r < link_i.vic_count) ||
                    ((count_r == link_i.vic_count) && (rank_r > link_i.vic_rank)));

  always_comb begin
    link_nxt = link_i;
    if (match) begin
      link_nxt.hit      = 1'b1;
      link_nxt.hit_rank = rank_r;
      link_nxt.rd_value = value_r;
    end
    if (!valid_r && !link_i.free_found) begin
      link_nxt.free_found = 1'b1;
      link_nxt.free_idx   = MY_IDX;
    end
    if (take_vic) begin
      link_nxt.vic_found = 1'b1;
      link_nxt.vic_count = count_r;
      link_nxt.vic_rank  = rank_r;
      link_nxt.vic_key   = key_r;
      link_nxt.vic_idx   = MY_IDX;
    end
  end

  assign is_vic   = cmd_i.evict && (cmd_i.vic_idx == MY_IDX);
  assign is_ins   = cmd_i.insert && (cmd_i.ins_idx == MY_IDX);
  assign rank_dec = cmd_i.evict && (rank_r > cmd_i.vic_rank);

  always_ff @(posedge clk) begin
    // The scan payload moves down the chain every cycle and needs no reset.
    link_r.hit        <= link_nxt.hit;
    link_r.hit_rank   <= link_nxt.hit_rank;
    link_r.rd_value   <= link_nxt.rd_value;
    link_r.free_found <= link_nxt.free_found;
    link_r.free_idx   <= link_nxt.free_idx;
    link_r.vic_found  <= link_nxt.vic_found;
    link_r.vic_count  <= link_nxt.vic_count;
    link_r.vic_rank   <= link_nxt.vic_rank;
    link_r.vic_key    <= link_nxt.vic_key;
    link_r.vic_idx    <= link_nxt.vic_idx;
    if (!rst_n) begin
      link_r.tok <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      link_r.tok <= link_nxt.tok;
      if (cmd_i.en) begin
        if (cmd_i.touch) begin
          if (match) begin
            rank_r <= '0;
            if (count_r != '1) begin
              count_r <= count_r + CNT_W'(1);
            end
            if (cmd_i.wr_value) begin
              value_r <= cmd_i.value;
            end
          end else if (valid_r && (rank_r < cmd_i.hit_rank)) begin
            rank_r <= rank_r + IDX_W'(1);
          end
        end else if (is_ins) begin
          valid_r <= 1'b1;
          key_r   <= key_i;
          value_r <= cmd_i.value;
          count_r <= CNT_W'(1);
          rank_r  <= '0;
        end else if (is_vic) begin
          valid_r <= 1'b0;
        end else if (valid_r) begin
          rank_r <= rank_r - IDX_W'(rank_dec) + IDX_W'(cmd_i.insert);
        end
      end
    end
  end

  assign link_o = link_r;

endmodule

`default_nettype wire

// File: rtl/lfu_cache_key_value_store.sv
// ----------------------------------------------------------------------------
// lfu_cache_key_value_store
// Key/value cache with least-frequently-used replacement and a least-recently-
// used tie-break, built as a chain of slot cells scanned one cell per cycle.
// ----------------------------------------------------------------------------
// The scan record for key match, free slot and victim ripples down the chain one
// cell per cycle, then the update command is broadcast to all cells; start is
// taken again at the end of the cycle that shows the result, so a new request
// is not accepted while one is in flight. The receiver cannot stall.
// Reset clears all valid bits and the occupancy and sets capacity to 16; the
// slot contents are not cleared and no clearing pass is needed.
`default_nettype none

module lfu_cache_key_value_store
  import lfukv_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_opcode,
  input  wire logic signed [KEY_W-1:0] in_lookup_key,
  input  wire logic signed [VAL_W-1:0] in_put_value,
  output logic                         out_strobe,
  output logic                         out_hit,
  output logic signed [VAL_W-1:0]      out_read_value,
  output logic                         out_evicted,
  output logic signed [KEY_W-1:0]      out_evicted_key,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CAP_W-1:0]        cfg_capacity
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef struct packed {
    logic                  tok;
    logic                  hit;
    logic [IDX_W-1:0]      hit_rank;
    logic [VAL_W-1:0]      rd_value;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic                  vic_found;
    logic [COUNT_BITS-1:0] vic_count;
    logic [IDX_W-1:0]      vic_rank;
    logic [KEY_W-1:0]      vic_key;
    logic [IDX_W-1:0]      vic_idx;
  } link_t;

  typedef struct packed {
    logic             en;
    logic             touch;
    logic             wr_value;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] hit_rank;
    logic             evict;
    logic [IDX_W-1:0] vic_idx;
    logic [IDX_W-1:0] vic_rank;
    logic             insert;
    logic [IDX_W-1:0] ins_idx;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r;

  logic             launch_r;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CAP_W-1:0] cap_r;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  logic             strobe_r;
  logic             hit_r;
  logic [VAL_W-1:0] rd_r;
  logic             ev_r;
  logic [KEY_W-1:0] evk_r;

  link_t links [ENTRIES+1];
  link_t fin;
  cmd_t  cmd;

  logic          accept;
  logic          done;
  logic          is_put;
  logic          cap_ok;
  logic          full;
  logic          miss_ins;
  logic          evict;
  logic          use_free;
  logic [CW-1:0] cap_w;
  logic [CW-1:0] cap_eff;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_comb begin
    links[0]     = '0;
    links[0].tok = launch_r;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfukv_cell #(
      .CELL_IDX (g),
      .IDX_W    (IDX_W),
      .CNT_W    (COUNT_BITS),
      .link_t   (link_t),
      .cmd_t    (cmd_t)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key_i  (key_r),
      .link_i (links[g]),
      .link_o (links[g+1]),
      .cmd_i  (cmd)
    );
  end

  assign fin = links[ENTRIES];

  // Capacity above the number of slots acts as the number of slots.
  assign cap_w   = CW'(cap_r);
  assign cap_eff = (cap_w > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_w;

  assign done     = (state_r == ST_SCAN) && fin.tok;
  assign is_put   = (op_r == OP_PUT);
  assign cap_ok   = (cap_eff != '0);
  assign full     = (CW'(occ_r) >= cap_eff);
  assign miss_ins = is_put && cap_ok && !fin.hit;
  assign evict    = miss_ins && full && fin.vic_found;

  // After an eviction the lowest free slot is the lower of the old free slot
  // and the victim's slot.
  assign use_free = fin.free_found && (!evict || (fin.free_idx < fin.vic_idx));

  always_comb begin
    cmd          = '0;
    cmd.en       = done;
    cmd.touch    = fin.hit && (!is_put || cap_ok);
    cmd.wr_value = is_put;
    cmd.value    = val_r;
    cmd.hit_rank = fin.hit_rank;
    cmd.evict    = evict;
    cmd.vic_idx  = fin.vic_idx;
    cmd.vic_rank = fin.vic_rank;
    cmd.insert   = miss_ins;
    cmd.ins_idx  = use_free ? fin.free_idx : fin.vic_idx;
  end

  assign occ_nxt = occ_r - OCC_W'(evict) + OCC_W'(miss_ins);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      launch_r <= 1'b0;
      strobe_r <= 1'b0;
      occ_r    <= '0;
      cap_r    <= CAP_RESET;
    end else begin
      launch_r <= accept;
      strobe_r <= done;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (done) begin
            state_r <= ST_IDLE;
            occ_r   <= occ_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (accept) begin
        op_r  <= in_opcode;
        key_r <= in_lookup_key;
        val_r <= in_put_value;
      end
      if (done) begin
        hit_r <= fin.hit;
        rd_r  <= (!is_put && fin.hit) ? fin.rd_value : '0;
        ev_r  <= evict;
        evk_r <= evict ? fin.vic_key : '0;
      end
    end
  end

  assign out_strobe      = strobe_r;
  assign out_hit         = hit_r;
  assign out_read_value  = rd_r;
  assign out_evicted     = ev_r;
  assign out_evicted_key = evk_r;

endmodule

`default_nettype wire

// File: tb/lfu_cache_checker.sv
// ----------------------------------------------------------------------------
// lfu_cache_checker
// Watches the request, result and capacity channels of the LFU key/value
// cache, keeps its own copy of the cache contents, predicts the result of
// every accepted request and compares each result strobe against it.
// ----------------------------------------------------------------------------
module lfu_cache_checker
  import lfukv_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_opcode,
  input  logic signed [KEY_W-1:0] in_lookup_key,
  input  logic signed [VAL_W-1:0] in_put_value,
  input  logic                    out_strobe,
  input  logic                    out_hit,
  input  logic signed [VAL_W-1:0] out_read_value,
  input  logic                    out_evicted,
  input  logic signed [KEY_W-1:0] out_evicted_key,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_capacity,
  output int                      pending,
  output int                      failures,
  output int                      checked,
  output int                      hits,
  output int                      evictions
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;
  localparam int QUEUE_DEPTH = 8;
  localparam logic [COUNT_BITS-1:0] USES_MAX = '1;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } access_result_t;

  // Shadow copy of the cache. The age of a valid slot is the number of valid
  // slots touched more recently than it.
  logic                  slot_valid [ENTRIES];
  logic [KEY_W-1:0]      slot_key   [ENTRIES];
  logic [VAL_W-1:0]      slot_value [ENTRIES];
  logic [COUNT_BITS-1:0] slot_uses  [ENTRIES];
  int unsigned           slot_age   [ENTRIES];
  int unsigned           fill;
  logic [CAP_W-1:0]      cap_reg;

  // Predicted results waiting for their strobe, kept as a ring.
  access_result_t expected_results [QUEUE_DEPTH];
  int             exp_head;
  int             exp_count;
  access_result_t outcome;
  access_result_t want;
  int             fail_cnt;
  int             check_cnt;
  int             hit_cnt;
  int             evict_cnt;

  function automatic void promote_slot(int s);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    end
    slot_age[s] = 0;
    if (slot_uses[s] != USES_MAX) slot_uses[s]++;
  endfunction

  function automatic access_result_t access_cache(logic op, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] val);
    access_result_t r;
    int             found;
    int             victim;
    int             free_slot;
    int unsigned    eff_cap;
    r         = '0;
    found     = -1;
    victim    = -1;
    free_slot = -1;
    eff_cap   = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    end
    r.hit = (found >= 0);
    if (op == OP_GET) begin
      if (found >= 0) begin
        r.read_value = slot_value[found];
        promote_slot(found);
      end
    end else if (eff_cap != 0) begin
      if (found >= 0) begin
        slot_value[found] = val;
        promote_slot(found);
      end else begin
        // With the cache full (or over a lowered capacity) exactly one entry
        // goes: lowest use count, oldest among equal counts.
        if (fill >= eff_cap) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            r.evicted          = 1'b1;
            r.evicted_key      = slot_key[victim];
            slot_valid[victim] = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_valid[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
            end
            fill--;
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_slot < 0 && !slot_valid[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) slot_age[i]++;
          end
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot]   = key;
          slot_value[free_slot] = val;
          slot_uses[free_slot]  = 1;
          slot_age[free_slot]   = 0;
          fill++;
        end
      end
    end
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, exp_val,
                 got_val);
      if (fail_cnt == MAX_REPORTS) $display("Further mismatch reports suppressed.");
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      fill      = 0;
      cap_reg   = CAP_RESET;
      exp_head  = 0;
      exp_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_capacity;
      // Results are matched before the request of the same edge is queued.
      if (out_strobe) begin
        if (exp_count == 0) begin
          fail_cnt++;
          $display("%0t ns: result strobe with no request outstanding, actual hit %b "
                   , $time, out_hit);
        end else begin
          want      = expected_results[exp_head];
          exp_head  = (exp_head + 1) % QUEUE_DEPTH;
          exp_count = exp_count - 1;
          compare_field("hit", 32'(want.hit), 32'(out_hit));
          compare_field("read_value", want.read_value, out_read_value);
          compare_field("evicted", 32'(want.evicted), 32'(out_evicted));
          compare_field("evicted_key", want.evicted_key, out_evicted_key);
          check_cnt++;
          if (want.hit) hit_cnt++;
          if (want.evicted) evict_cnt++;
        end
      end
      if (start && !busy) begin
        outcome = access_cache(in_opcode, in_lookup_key, in_put_value);
        if (exp_count == QUEUE_DEPTH) begin
          fail_cnt++;
          $display("%0t ns: too many requests outstanding, expected at most %0d, actual %0d",
                   $time, QUEUE_DEPTH, exp_count + 1);
        end else begin
          expected_results[(exp_head + exp_count) % QUEUE_DEPTH] = outcome;
          exp_count = exp_count + 1;
        end
      end
    end
    pending   <= exp_count;
    failures  <= fail_cnt;
    checked   <= check_cnt;
    hits      <= hit_cnt;
    evictions <= evict_cnt;
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives get and put requests and capacity writes into the LFU key/value
// cache: a directed opening, then random phases over a range of capacities
// with random gaps on the request and configuration channels.
// ----------------------------------------------------------------------------
module tb_top
  import lfukv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES         = 16;
  // A four-bit use count saturates at 15, so a hot key soon reaches the limit.
  localparam int COUNT_BITS      = 4;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 10;
  localparam int POOL_MAX        = 2 * ENTRIES + 4;
  localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] =
    '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd3, 5'd8, 5'd5, 5'd16};

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    start           = 1'b0;
  logic                    busy;
  logic                    in_opcode       = OP_GET;
  logic signed [KEY_W-1:0] in_lookup_key   = '0;
  logic signed [VAL_W-1:0] in_put_value    = '0;
  logic                    out_strobe;
  logic                    out_hit;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    out_evicted;
  logic signed [KEY_W-1:0] out_evicted_key;
  logic                    cfg_valid       = 1'b0;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_capacity    = '0;

  int pending;
  int failures;
  int checked;
  int hits;
  int evictions;
  int requests_sent;
  int cap_writes;
  int idle_pct;
  int quiet_cycles;
  int pool_size;

  logic [KEY_W-1:0] key_pool [POOL_MAX];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lfu_cache_key_value_store #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_lookup_key  (in_lookup_key),
    .in_put_value   (in_put_value),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  lfu_cache_checker #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_lookup_key  (in_lookup_key),
    .in_put_value   (in_put_value),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .pending        (pending),
    .failures       (failures),
    .checked        (checked),
    .hits           (hits),
    .evictions      (evictions)
  );

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Mostly keys from a pool a little larger than the capacity, so that hits,
  // updates and evictions all happen often.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll = $urandom_range(0, 99);
    if (roll < 6) return $urandom;
    if (roll < 10) return corner_word();
    return key_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return corner_word();
    return $urandom;
  endfunction

  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_lookup_key <= key;
    in_put_value  <= val;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // The register is only written with no transaction in flight.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    if (idle_pct != 0 && $urandom_range(0, 1) == 0) repeat ($urandom_range(1, 17)) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  initial begin
    int unsigned eff_cap;
    requests_sent = 0;
    cap_writes    = 0;
    idle_pct      = 20;
    pool_size     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset capacity of 16.
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h0001_2345, 32'h0000_0000);
    // Capacity below the occupancy: each new key swaps out exactly one entry,
    // and the freshly inserted key is itself the next victim.
    write_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_0005, 32'h0000_0055);
    send_request(OP_PUT, 32'h0000_0006, 32'h0000_0066);
    // Capacity zero: puts change nothing but still report presence.
    write_capacity(5'd0);
    send_request(OP_PUT, 32'h0000_0007, 32'h0000_0077);
    send_request(OP_PUT, 32'h0000_0006, 32'hDEAD_BEEF);
    send_request(OP_GET, 32'h0000_0006, 32'h0000_0000);
    // Capacity above the slot count behaves as a full-size cache.
    write_capacity(5'd31);
    send_request(OP_PUT, 32'h0000_0008, 32'h0000_0088);
    send_request(OP_GET, 32'h0000_0007, 32'h0000_0000);
    write_capacity(5'd1);
    send_request(OP_PUT, 32'h0000_0009, 32'h0000_0099);
    send_request(OP_GET, 32'h0000_0008, 32'h0000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (p == NUM_PHASES - 1) idle_pct = 0;
      write_capacity(PHASE_CAPS[p]);
      // A zero-capacity phase keeps the previous pool so that gets still hit.
      if (PHASE_CAPS[p] != 0) begin
        eff_cap   = (PHASE_CAPS[p] > ENTRIES) ? ENTRIES : PHASE_CAPS[p];
        pool_size = eff_cap + 2 + $urandom_range(0, eff_cap / 2 + 2);
        for (int k = 0; k < pool_size; k++) key_pool[k] = $urandom;
      end
      repeat (ITEMS_PER_PHASE) begin
        send_request($urandom_range(0, 1) ? OP_PUT : OP_GET, pick_key(), pick_value());
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (ENTRIES + 4) @(posedge clk);

    $display("Summary: %0d requests over %0d capacity writes (0 through 31),", requests_sent,
             cap_writes);
    $display("Summary: %0d results checked, %0d hits, %0d evictions, %0d mismatches.",
             checked, hits, evictions, failures);
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d results outstanding", $time, pending);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
